// File: src/obd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package obd_pkg;

   typedef enum logic {
      ACTION_TICK  = 1'b0,
      ACTION_FRAME = 1'b1
   } obd_action_type;

   typedef enum logic {
      KIND_REQUEST = 1'b0,
      KIND_READING = 1'b1
   } obd_kind_type;

   localparam logic [2:0] QTY_RPM      = 3'd0;
   localparam logic [2:0] QTY_SPEED    = 3'd1;
   localparam logic [2:0] QTY_LOAD     = 3'd2;
   localparam logic [2:0] QTY_THROTTLE = 3'd3;
   localparam logic [2:0] QTY_COOLANT  = 3'd4;
   localparam logic [2:0] QTY_UNKNOWN  = 3'd5;

   localparam logic [7:0] PID_RPM      = 8'h0C;
   localparam logic [7:0] PID_SPEED    = 8'h0D;
   localparam logic [7:0] PID_LOAD     = 8'h04;
   localparam logic [7:0] PID_THROTTLE = 8'h11;
   localparam logic [7:0] PID_COOLANT  = 8'h05;

   localparam logic [7:0] MODE01_REPLY = 8'h41;

   localparam logic [1:0] CSR_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_ID_LOW   = 2'd1;
   localparam logic [1:0] CSR_ID_HIGH  = 2'd2;

   localparam int         CSR_WIDTH          = 16;
   localparam logic [15:0] INTERVAL_RESET    = 16'd100;
   localparam logic [10:0] ID_LOW_RESET      = 11'h7E8;
   localparam logic [10:0] ID_HIGH_RESET     = 11'h7EF;

   typedef struct packed {
      obd_kind_type kind;
      logic [7:0]   pid;
      logic [2:0]   quantity;
      logic [7:0]   byte_a;
      logic [7:0]   byte_b;
      logic [63:0]  stamp_us;
   } obd_op_type;

   typedef struct packed {
      logic       push;
      obd_op_type op;
   } obd_push_type;

   typedef struct packed {
      obd_kind_type       kind;
      logic [7:0]         pid;
      logic [2:0]         quantity;
      logic signed [14:0] value;
      logic [63:0]        stamp_us;
   } obd_rsp_type;

   // round-robin poll list, slot number equals the quantity code
   function automatic logic [7:0] poll_pid(input logic [2:0] slot);
      logic [7:0] pid;
      case (slot)
         3'd0:    pid = PID_RPM;
         3'd1:    pid = PID_SPEED;
         3'd2:    pid = PID_LOAD;
         3'd3:    pid = PID_THROTTLE;
         3'd4:    pid = PID_COOLANT;
         default: pid = PID_RPM;
      endcase
      return pid;
   endfunction

endpackage
`default_nettype wire

// File: src/obd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module obd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fifo count above depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("fifo count missed a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("fifo pointers apart while empty");

endmodule
`default_nettype wire

// File: src/obd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module obd_front
   import obd_pkg::*;
#(
   parameter int NUM_POLLED = 5
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire logic           mid_full,
   input  wire obd_action_type action,
   input  wire logic [10:0]    frame_id,
   input  wire logic [3:0]     frame_length,
   input  wire logic [7:0]     mode_byte,
   input  wire logic [7:0]     pid_byte,
   input  wire logic [7:0]     byte_a,
   input  wire logic [7:0]     byte_b,
   input  wire logic [63:0]    now_us,
   input  wire logic           csr_we,
   input  wire logic [1:0]     csr_index,
   input  wire logic [CSR_WIDTH-1:0] csr_wdata,
   output obd_push_type        to_back
);

   localparam logic [2:0] NUM_W = 3'(NUM_POLLED);

   logic [15:0] interval_ff;
   logic [10:0] id_low_ff, id_high_ff;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [2:0]  poll_ff, poll_in;
   logic [15:0] count_up;
   logic [2:0]  slot;
   logic        take, fire, frame_ok;

   assign take     = push & ~mid_full;
   assign count_up = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 1'b1;
   assign fire     = (count_up >= interval_ff);
   assign slot     = (poll_ff >= NUM_W) ? 3'd0 : poll_ff;
   assign frame_ok = (frame_id >= id_low_ff) && (frame_id <= id_high_ff)
                     && (frame_length >= 4'd3) && (mode_byte == MODE01_REPLY);

   always_comb begin
      elapsed_in = elapsed_ff;
      poll_in    = poll_ff;
      to_back.push        = 1'b0;
      to_back.op.kind     = KIND_REQUEST;
      to_back.op.pid      = poll_pid(slot);
      to_back.op.quantity = slot;
      to_back.op.byte_a   = '0;
      to_back.op.byte_b   = '0;
      to_back.op.stamp_us = '0;
      if (take) begin
         if (action == ACTION_TICK) begin
            elapsed_in = fire ? '0 : count_up;
            if (fire) begin
               poll_in      = (slot == NUM_W - 3'd1) ? 3'd0 : slot + 3'd1;
               to_back.push = 1'b1;
            end
         end else if (frame_ok) begin
            to_back.push        = 1'b1;
            to_back.op.kind     = KIND_READING;
            to_back.op.pid      = pid_byte;
            to_back.op.quantity = QTY_UNKNOWN;
            // value bytes missing from a short frame read as zero
            to_back.op.byte_a   = (frame_length > 4'd3) ? byte_a : 8'd0;
            to_back.op.byte_b   = (frame_length > 4'd4) ? byte_b : 8'd0;
            to_back.op.stamp_us = now_us;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         id_low_ff   <= ID_LOW_RESET;
         id_high_ff  <= ID_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INTERVAL: interval_ff <= csr_wdata;
            CSR_ID_LOW:   id_low_ff   <= csr_wdata[10:0];
            CSR_ID_HIGH:  id_high_ff  <= csr_wdata[10:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         poll_ff    <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         poll_ff    <= poll_in;
      end
   end

   a_poll_range: assert property (@(posedge clock) disable iff (reset)
      poll_ff < NUM_W)
      else $error("poll index out of range");

   a_clear_on_request: assert property (@(posedge clock) disable iff (reset)
      (to_back.push && to_back.op.kind == KIND_REQUEST) |=> elapsed_ff == '0)
      else $error("tick count not cleared after request");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      to_back.push |-> !mid_full)
      else $error("transfer into full queue");

endmodule
`default_nettype wire

// File: src/obd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module obd_back
   import obd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        mid_empty,
   input  wire obd_op_type  head,
   output logic             mid_pop,
   input  wire logic        pop,
   output logic             empty,
   output obd_rsp_type      rsp
);

   obd_rsp_type        dec;
   logic               out_full;
   logic [14:0]        pct_x;
   logic [22:0]        pct_prod;
   logic [6:0]         pct_q0;
   logic [14:0]        pct_rem;
   logic [6:0]         pct_q;

   // a * 100 / 255: reciprocal estimate is low by at most one, one fix-up step
   assign pct_x    = 15'(head.byte_a) * 15'd100;
   assign pct_prod = 23'(pct_x) * 23'd257;
   assign pct_q0   = pct_prod[22:16];
   assign pct_rem  = pct_x - 15'(pct_q0) * 15'd255;
   assign pct_q    = (pct_rem >= 15'd255) ? pct_q0 + 7'd1 : pct_q0;

   always_comb begin
      dec.kind     = head.kind;
      dec.pid      = head.pid;
      dec.quantity = head.quantity;
      dec.value    = '0;
      dec.stamp_us = head.stamp_us;
      if (head.kind == KIND_READING) begin
         case (head.pid)
            PID_RPM: begin
               dec.quantity = QTY_RPM;
               dec.value    = $signed({1'b0, head.byte_a, head.byte_b[7:2]});
            end
            PID_SPEED: begin
               dec.quantity = QTY_SPEED;
               dec.value    = $signed({7'd0, head.byte_a});
            end
            PID_LOAD: begin
               dec.quantity = QTY_LOAD;
               dec.value    = $signed({8'd0, pct_q});
            end
            PID_THROTTLE: begin
               dec.quantity = QTY_THROTTLE;
               dec.value    = $signed({8'd0, pct_q});
            end
            PID_COOLANT: begin
               dec.quantity = QTY_COOLANT;
               dec.value    = $signed({7'd0, head.byte_a}) - 15'sd40;
            end
            default: begin
               dec.quantity = QTY_UNKNOWN;
            end
         endcase
      end
   end

   assign mid_pop = ~mid_empty & ~out_full;

   obd_fifo #(
      .WIDTH ($bits(obd_rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_pop),
      .push_data (dec),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (rsp),
      .empty     (empty)
   );

endmodule
`default_nettype wire

// File: src/obd2_pid_poll_and_decode_unit.sv
// OBD-II mode 01 poller and decoder. Millisecond tick items advance a saturating counter;
// when it reaches request_interval a request result (kind 0, pid, quantity slot) is queued
// for the next PID of the round-robin list 0C, 0D, 04, 11, 05 and the counter clears.
// Frame items inside [response_id_low, response_id_high] with length >= 3 and mode byte
// 0x41 produce a decoded reading with the frame timestamp; other frames produce nothing.
// One item is taken every clock unless the middle queue is full: the front stage classifies
// and runs the poll counter, a queue of QUEUE_DEPTH entries hands work to the decode stage,
// which writes a result queue of the same depth. A result shows on the rsp_ ports once its
// item has been written into the middle queue and, decoded, into the result queue;
// throughput is one item per clock, limited only by the queue handshakes. CSR writes take
// effect on the next edge and should be done while idle.
`timescale 1ns / 1ps
`default_nettype none
module obd2_pid_poll_and_decode_unit
   import obd_pkg::*;
#(
   parameter int NUM_POLLED  = 5,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_action,
   input  wire logic [10:0] req_frame_id,
   input  wire logic [3:0]  req_frame_length,
   input  wire logic [7:0]  req_mode_byte,
   input  wire logic [7:0]  req_pid_byte,
   input  wire logic [7:0]  req_byte_a,
   input  wire logic [7:0]  req_byte_b,
   input  wire logic [63:0] req_now_us,
   output logic             empty,
   input  wire logic        pop,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_pid,
   output logic [2:0]       rsp_quantity,
   output logic signed [14:0] rsp_value,
   output logic [63:0]      rsp_stamp_us,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [CSR_WIDTH-1:0] csr_wdata
);

   obd_push_type to_back;
   obd_op_type   head;
   obd_rsp_type  rsp;
   logic         mid_full, mid_empty, mid_pop;

   assign full = mid_full;

   obd_front #(
      .NUM_POLLED (NUM_POLLED)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .mid_full     (mid_full),
      .action       (obd_action_type'(req_action)),
      .frame_id     (req_frame_id),
      .frame_length (req_frame_length),
      .mode_byte    (req_mode_byte),
      .pid_byte     (req_pid_byte),
      .byte_a       (req_byte_a),
      .byte_b       (req_byte_b),
      .now_us       (req_now_us),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .to_back      (to_back)
   );

   obd_fifo #(
      .WIDTH ($bits(obd_op_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (to_back.push),
      .push_data (to_back.op),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (head),
      .empty     (mid_empty)
   );

   obd_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .head      (head),
      .mid_pop   (mid_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp)
   );

   assign rsp_result_kind = rsp.kind;
   assign rsp_pid         = rsp.pid;
   assign rsp_quantity    = rsp.quantity;
   assign rsp_value       = rsp.value;
   assign rsp_stamp_us    = rsp.stamp_us;

endmodule
`default_nettype wire

// File: bench/obd2_poll_decode_checker.sv
`timescale 1ns / 1ps
module obd2_poll_decode_checker
   import obd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 full,
   input  logic                 req_action,
   input  logic [10:0]          req_frame_id,
   input  logic [3:0]           req_frame_length,
   input  logic [7:0]           req_mode_byte,
   input  logic [7:0]           req_pid_byte,
   input  logic [7:0]           req_byte_a,
   input  logic [7:0]           req_byte_b,
   input  logic [63:0]          req_now_us,
   input  logic                 empty,
   input  logic                 pop,
   input  logic                 rsp_result_kind,
   input  logic [7:0]           rsp_pid,
   input  logic [2:0]           rsp_quantity,
   input  logic signed [14:0]   rsp_value,
   input  logic [63:0]          rsp_stamp_us,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata,
   output int                   fail_count,
   output int                   pending_count,
   output int                   requests_seen,
   output int                   readings_seen
);

   localparam int NUM_SLOTS = 5;

   logic [15:0] interval_cfg;
   logic [10:0] id_low_cfg;
   logic [10:0] id_high_cfg;
   logic [15:0] tick_count;
   logic [2:0]  poll_slot;
   logic [15:0] stored_value [NUM_SLOTS];
   logic [63:0] stored_stamp [NUM_SLOTS];
   logic [63:0] last_rx_stamp;

   obd_rsp_type reading_q [$];

   // one millisecond tick: advance the poll counter, maybe issue a request
   function automatic bit advance_poll(output obd_rsp_type r);
      logic [2:0] slot;
      r = '0;
      if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
      if (tick_count < interval_cfg) return 1'b0;
      tick_count = '0;
      slot = (poll_slot >= NUM_SLOTS) ? 3'd0 : poll_slot;
      case (slot)
         3'd0:    r.pid = PID_RPM;
         3'd1:    r.pid = PID_SPEED;
         3'd2:    r.pid = PID_LOAD;
         3'd3:    r.pid = PID_THROTTLE;
         default: r.pid = PID_COOLANT;
      endcase
      r.kind = KIND_REQUEST;
      r.quantity = slot;
      poll_slot = (slot == NUM_SLOTS - 1) ? 3'd0 : slot + 3'd1;
      return 1'b1;
   endfunction

   function automatic bit decode_frame(output obd_rsp_type r);
      int a;
      int b;
      int v;
      logic [2:0] qty;
      r = '0;
      if (req_frame_id < id_low_cfg || req_frame_id > id_high_cfg) return 1'b0;
      if (req_frame_length < 4'd3 || req_mode_byte != MODE01_REPLY) return 1'b0;
      // short frames read the missing value bytes as zero
      a = (req_frame_length > 4'd3) ? int'(req_byte_a) : 0;
      b = (req_frame_length > 4'd4) ? int'(req_byte_b) : 0;
      case (req_pid_byte)
         PID_RPM:      begin qty = QTY_RPM;      v = (a * 256 + b) / 4; end
         PID_SPEED:    begin qty = QTY_SPEED;    v = a; end
         PID_LOAD:     begin qty = QTY_LOAD;     v = (a * 100) / 255; end
         PID_THROTTLE: begin qty = QTY_THROTTLE; v = (a * 100) / 255; end
         PID_COOLANT:  begin qty = QTY_COOLANT;  v = a - 40; end
         default:      begin qty = QTY_UNKNOWN;  v = 0; end
      endcase
      if (qty != QTY_UNKNOWN) begin
         stored_value[qty] = v[15:0];
         stored_stamp[qty] = req_now_us;
      end
      last_rx_stamp = req_now_us;
      r.kind = KIND_READING;
      r.pid = req_pid_byte;
      r.quantity = qty;
      r.value = v[14:0];
      r.stamp_us = req_now_us;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      obd_rsp_type r;
      obd_rsp_type want;
      bit made;
      if (reset) begin
         interval_cfg = INTERVAL_RESET;
         id_low_cfg = ID_LOW_RESET;
         id_high_cfg = ID_HIGH_RESET;
         tick_count = '0;
         poll_slot = '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            stored_value[i] = '0;
            stored_stamp[i] = '0;
         end
         last_rx_stamp = '0;
         reading_q.delete();
         fail_count = 0;
         pending_count = 0;
         requests_seen = 0;
         readings_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_INTERVAL: interval_cfg = csr_wdata[15:0];
               CSR_ID_LOW:   id_low_cfg = csr_wdata[10:0];
               CSR_ID_HIGH:  id_high_cfg = csr_wdata[10:0];
               default: ;
            endcase
         end
         if (push && !full) begin
            if (req_action == ACTION_TICK) made = advance_poll(r);
            else made = decode_frame(r);
            if (made) reading_q.push_back(r);
         end
         if (pop && !empty) begin
            if (reading_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected transfer: kind %0d pid %02h qty %0d value %0d stamp %0h",
                        $time, rsp_result_kind, rsp_pid, rsp_quantity, rsp_value, rsp_stamp_us);
            end else begin
               want = reading_q.pop_front();
               if (rsp_result_kind !== want.kind) begin
                  fail_count++;
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                           rsp_result_kind);
               end
               if (rsp_pid !== want.pid) begin
                  fail_count++;
                  $display("%0t: pid expected %02h actual %02h", $time, want.pid, rsp_pid);
               end
               if (rsp_quantity !== want.quantity) begin
                  fail_count++;
                  $display("%0t: quantity expected %0d actual %0d", $time, want.quantity,
                           rsp_quantity);
               end
               if (rsp_value !== want.value) begin
                  fail_count++;
                  $display("%0t: value expected %0d actual %0d", $time,
                           $signed(want.value), rsp_value);
               end
               if (rsp_stamp_us !== want.stamp_us) begin
                  fail_count++;
                  $display("%0t: stamp expected %0h actual %0h", $time, want.stamp_us,
                           rsp_stamp_us);
               end
               if (want.kind == KIND_REQUEST) requests_seen++;
               else readings_seen++;
            end
         end
         pending_count = reading_q.size();
      end
   end

endmodule

// File: bench/obd2_pid_poll_and_decode_unit_tb.sv
`timescale 1ns / 1ps
module obd2_pid_poll_and_decode_unit_tb;
   import obd_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      obd_action_type action;
      logic [10:0]    frame_id;
      logic [3:0]     frame_length;
      logic [7:0]     mode_byte;
      logic [7:0]     pid_byte;
      logic [7:0]     byte_a;
      logic [7:0]     byte_b;
      logic [63:0]    now_us;
   } can_event_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 req_action = 1'b0;
   logic [10:0]          req_frame_id = '0;
   logic [3:0]           req_frame_length = '0;
   logic [7:0]           req_mode_byte = '0;
   logic [7:0]           req_pid_byte = '0;
   logic [7:0]           req_byte_a = '0;
   logic [7:0]           req_byte_b = '0;
   logic [63:0]          req_now_us = '0;
   logic                 pop = 1'b0;
   logic                 csr_we = 1'b0;
   logic [1:0]           csr_index = CSR_INTERVAL;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   logic                 full;
   logic                 empty;
   logic                 rsp_result_kind;
   logic [7:0]           rsp_pid;
   logic [2:0]           rsp_quantity;
   logic signed [14:0]   rsp_value;
   logic [63:0]          rsp_stamp_us;

   int fail_count;
   int pending_count;
   int requests_seen;
   int readings_seen;
   int items_sent = 0;
   int settings_used = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit push_eager = 1'b0;
   bit pop_eager = 1'b0;
   logic [10:0] id_low_now = ID_LOW_RESET;
   logic [10:0] id_high_now = ID_HIGH_RESET;

   always #10 clock = ~clock;

   obd2_pid_poll_and_decode_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_frame_id     (req_frame_id),
      .req_frame_length (req_frame_length),
      .req_mode_byte    (req_mode_byte),
      .req_pid_byte     (req_pid_byte),
      .req_byte_a       (req_byte_a),
      .req_byte_b       (req_byte_b),
      .req_now_us       (req_now_us),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_pid          (rsp_pid),
      .rsp_quantity     (rsp_quantity),
      .rsp_value        (rsp_value),
      .rsp_stamp_us     (rsp_stamp_us),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   obd2_poll_decode_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_frame_id     (req_frame_id),
      .req_frame_length (req_frame_length),
      .req_mode_byte    (req_mode_byte),
      .req_pid_byte     (req_pid_byte),
      .req_byte_a       (req_byte_a),
      .req_byte_b       (req_byte_b),
      .req_now_us       (req_now_us),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_pid          (rsp_pid),
      .rsp_quantity     (rsp_quantity),
      .rsp_value        (rsp_value),
      .rsp_stamp_us     (rsp_stamp_us),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .requests_seen    (requests_seen),
      .readings_seen    (readings_seen)
   );

   // mostly no gap, some short ones, a few long ones
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (stall_left > 0 && !pop_eager) begin
         pop <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         pop <= 1'b1;
         stall_left = draw_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic can_event_type tick_event();
      can_event_type ev;
      ev.action = ACTION_TICK;
      ev.frame_id = 11'($urandom_range(0, 2047));
      ev.frame_length = 4'($urandom_range(0, 15));
      ev.mode_byte = 8'($urandom_range(0, 255));
      ev.pid_byte = 8'($urandom_range(0, 255));
      ev.byte_a = 8'($urandom_range(0, 255));
      ev.byte_b = 8'($urandom_range(0, 255));
      ev.now_us = {$urandom(), $urandom()};
      return ev;
   endfunction

   function automatic can_event_type frame_event(input logic [10:0] id, input logic [3:0] len,
                                                 input logic [7:0] mode, input logic [7:0] pid,
                                                 input logic [7:0] a, input logic [7:0] b,
                                                 input logic [63:0] stamp);
      can_event_type ev;
      ev.action = ACTION_FRAME;
      ev.frame_id = id;
      ev.frame_length = len;
      ev.mode_byte = mode;
      ev.pid_byte = pid;
      ev.byte_a = a;
      ev.byte_b = b;
      ev.now_us = stamp;
      return ev;
   endfunction

   // mostly well-formed replies inside the window, some ticks, some noise
   function automatic can_event_type random_event();
      can_event_type ev;
      int p;
      ev = tick_event();
      p = $urandom_range(0, 99);
      if (p < 35) return ev;
      ev.action = ACTION_FRAME;
      if (p < 85) begin
         if (id_low_now <= id_high_now)
            ev.frame_id = 11'($urandom_range(id_low_now, id_high_now));
         ev.frame_length = 4'($urandom_range(3, 15));
         ev.mode_byte = MODE01_REPLY;
         case ($urandom_range(0, 5))
            0: ev.pid_byte = PID_RPM;
            1: ev.pid_byte = PID_SPEED;
            2: ev.pid_byte = PID_LOAD;
            3: ev.pid_byte = PID_THROTTLE;
            4: ev.pid_byte = PID_COOLANT;
            default: ;
         endcase
      end else begin
         // half of these sit just outside the window, the rest keep a random id
         if ($urandom_range(0, 1) == 0)
            ev.frame_id = ($urandom_range(0, 1) == 0) ? id_low_now - 11'd1 : id_high_now + 11'd1;
         if ($urandom_range(0, 2) == 0) ev.mode_byte = MODE01_REPLY;
      end
      return ev;
   endfunction

   task automatic send(input can_event_type ev);
      int gap;
      push <= 1'b1;
      req_action <= ev.action;
      req_frame_id <= ev.frame_id;
      req_frame_length <= ev.frame_length;
      req_mode_byte <= ev.mode_byte;
      req_pid_byte <= ev.pid_byte;
      req_byte_a <= ev.byte_a;
      req_byte_b <= ev.byte_b;
      req_now_us <= ev.now_us;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
      gap = push_eager ? 0 : draw_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain all expected results, then allow for ticks still in the pipeline
   task automatic settle();
      push <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] interval, input logic [10:0] lo,
                            input logic [10:0] hi);
      csr_we <= 1'b1;
      csr_index <= CSR_INTERVAL;
      csr_wdata <= interval;
      @(posedge clock);
      // junk in the unused upper bits must be dropped
      csr_index <= CSR_ID_LOW;
      csr_wdata <= {5'($urandom_range(0, 31)), lo};
      @(posedge clock);
      csr_index <= CSR_ID_HIGH;
      csr_wdata <= {5'($urandom_range(0, 31)), hi};
      @(posedge clock);
      csr_we <= 1'b0;
      id_low_now = lo;
      id_high_now = hi;
      settings_used++;
   endtask

   initial begin
      logic [15:0] interval;
      logic [10:0] lo;
      logic [10:0] hi;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window and interval: each decode, short frames, rejects
      send(frame_event(11'h7E8, 4'd8, MODE01_REPLY, PID_RPM, 8'hFF, 8'hFF, '1));
      send(frame_event(11'h7EF, 4'd5, MODE01_REPLY, PID_RPM, 8'h00, 8'h00, '0));
      send(frame_event(11'h7E9, 4'd4, MODE01_REPLY, PID_RPM, 8'h12, 8'hFF, 64'h55AA));
      send(frame_event(11'h7EA, 4'd3, MODE01_REPLY, PID_SPEED, 8'hFF, 8'hFF, 64'h1));
      send(frame_event(11'h7EB, 4'd15, MODE01_REPLY, PID_LOAD, 8'hFF, 8'h00, 64'h2));
      send(frame_event(11'h7EC, 4'd4, MODE01_REPLY, PID_THROTTLE, 8'h80, 8'h00, 64'h3));
      send(frame_event(11'h7ED, 4'd4, MODE01_REPLY, PID_COOLANT, 8'h00, 8'h00, 64'h4));
      send(frame_event(11'h7EE, 4'd6, MODE01_REPLY, PID_COOLANT, 8'hFF, 8'h00, 64'h5));
      send(frame_event(11'h7E8, 4'd8, MODE01_REPLY, 8'h00, 8'hAA, 8'h55, 64'h6));
      send(frame_event(11'h7E8, 4'd8, MODE01_REPLY, 8'hFF, 8'hAA, 8'hAA, 64'h7));
      send(frame_event(11'h7E8, 4'd8, 8'h40, PID_SPEED, 8'h11, 8'h22, 64'h8));
      send(frame_event(11'h7E8, 4'd8, 8'hC1, PID_SPEED, 8'h11, 8'h22, 64'h8));
      send(frame_event(11'h7E8, 4'd2, MODE01_REPLY, PID_SPEED, 8'h11, 8'h22, 64'h9));
      send(frame_event(11'h7E7, 4'd8, MODE01_REPLY, PID_SPEED, 8'h11, 8'h22, 64'hA));
      send(frame_event(11'h7F0, 4'd8, MODE01_REPLY, PID_SPEED, 8'h11, 8'h22, 64'hB));
      repeat (3) send(tick_event());
      settle();

      // zero interval polls on every tick, full id window
      configure(16'd0, 11'd0, 11'h7FF);
      repeat (6) send(tick_event());
      send(frame_event(11'd0, 4'd5, MODE01_REPLY, PID_RPM, 8'h01, 8'h03, 64'hC));
      send(frame_event(11'h7FF, 4'd5, MODE01_REPLY, PID_SPEED, 8'h7F, 8'h03, 64'hD));
      settle();

      // interval lowered below the running count
      configure(16'd40, 11'h7E8, 11'h7EF);
      repeat (20) send(tick_event());
      settle();
      configure(16'd5, 11'h7E8, 11'h7EF);
      repeat (3) send(tick_event());
      settle();

      for (int k = 0; k < 12; k++) begin
         interval = (k % 3 == 0) ? 16'($urandom_range(1, 4)) : 16'($urandom_range(2, 12));
         lo = 11'($urandom_range(1, 2047));
         case (k % 4)
            0: begin lo = 11'd0; hi = 11'h7FF; end
            1: hi = (lo > 11'd2032) ? 11'h7FF : lo + 11'($urandom_range(0, 15));
            2: hi = lo;
            default: hi = 11'($urandom_range(0, lo - 1));
         endcase
         configure(interval, lo, hi);
         push_eager = (k % 4 == 1);
         pop_eager = (k % 4 == 2);
         repeat (100) send(random_event());
         settle();
      end
      push_eager = 1'b0;
      pop_eager = 1'b0;

      $display("sent %0d items over %0d register settings, intervals from zero to forty",
               items_sent, settings_used);
      $display("checked %0d poll requests and %0d decoded readings",
               requests_seen, readings_seen);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
src/obd_pkg.sv
src/obd_fifo.sv
src/obd_front.sv
src/obd_back.sv
src/obd2_pid_poll_and_decode_unit.sv
bench/obd2_poll_decode_checker.sv
bench/obd2_pid_poll_and_decode_unit_tb.sv
